// ----- design/dhtr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Document hit tally ranker package
// Shared widths, opcodes, register indexes and item types of the tally ranker.
// ----------------------------------------------------------------------------
package dhtr_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int LIST_MAX_DEF      = 20;

	localparam int NAME_W    = 40;
	localparam int COUNT_W   = 16;
	localparam int RANK_W    = 5;
	localparam int LIMIT_W   = 5;
	localparam int OPCODE_W  = 2;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
	localparam logic [LIMIT_W-1:0] LIST_LIMIT_RST = LIMIT_W'(20);

	localparam logic [OPCODE_W-1:0] OP_CLEAR  = OPCODE_W'(0);
	localparam logic [OPCODE_W-1:0] OP_RECORD = OPCODE_W'(1);
	localparam logic [OPCODE_W-1:0] OP_EMIT   = OPCODE_W'(2);

	localparam logic [REG_IDX_W-1:0] REG_LIST_LIMIT = REG_IDX_W'(0);

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [NAME_W-1:0]   doc_name;
	} item_t;

	typedef struct packed {
		logic [NAME_W-1:0]  ranked_name;
		logic [COUNT_W-1:0] hit_count;
		logic [RANK_W-1:0]  rank;
		logic               empty_list;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

// ----- design/dhtr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Tally ranker RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dhtr_ram #(
	parameter int WIDTH = dhtr_pkg::NAME_W,
	parameter int DEPTH = dhtr_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/document_hit_tally_ranker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Document hit tally ranker
// Counts hits per document name in a bounded table and emits a ranked list.
// ----------------------------------------------------------------------------
// Names and counts live in two RAMs with one read port each, and record and
// emit items walk the stored entries one per cycle. A record skips the scan
// on an empty table and stops early when the name is found. An emit gives k
// ranked results, each one a full pass over the stored counts, then a load
// into the output register that waits while the output is stalled. Each
// pass picks the next entry in descending count order, ties going to the
// earlier entry. An empty table gives a single item flagged empty. Results
// wait in an output register, so a new item is taken as soon as the last
// result of an emit is loaded.
// ----------------------------------------------------------------------------
module document_hit_tally_ranker_top #(
	parameter int TABLE_ENTRIES = dhtr_pkg::TABLE_ENTRIES_DEF,
	parameter int LIST_MAX      = dhtr_pkg::LIST_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dhtr_pkg::PADDR_W-1:0]  paddr,
	input  logic [dhtr_pkg::DATA_W-1:0]   pwdata,
	output logic [dhtr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  dhtr_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output dhtr_pkg::result_t             result
);

	import dhtr_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int RW = $clog2(LIST_MAX + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REC_SCAN,
		S_REC_APPEND,
		S_EMIT_SCAN,
		S_EMIT_OUT,
		S_EMIT_EMPTY
	} state_t;

	state_t              state_q;
	logic [LIMIT_W-1:0]  list_limit_q;
	logic [CW-1:0]       entry_count_q;
	logic [NAME_W-1:0]   key_q;
	logic [CW-1:0]       issue_q;
	logic                v_s1;
	logic [AW-1:0]       idx_s1;
	logic                best_valid_q;
	logic [COUNT_W-1:0]  best_count_q;
	logic [AW-1:0]       best_idx_q;
	logic [COUNT_W-1:0]  prev_count_q;
	logic [AW-1:0]       prev_idx_q;
	logic                first_q;
	logic [RW-1:0]       rank_q;
	logic [RW-1:0]       k_q;
	logic                result_valid_q;
	result_t             result_q;

	logic                cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                issue_en;
	logic                scan_last;
	logic                name_match;
	logic [COUNT_W-1:0]  count_inc;
	logic                eligible;
	logic                take;
	logic [AW-1:0]       best_idx_nxt;
	logic [COUNT_W-1:0]  best_count_nxt;
	logic                emit_end;
	logic                out_free;
	logic                out_load;
	logic                rec_hit;
	logic                append;
	logic                last_w;
	logic [RW-1:0]       k_nxt;

	logic                cnt_we;
	logic [AW-1:0]       cnt_waddr;
	logic [COUNT_W-1:0]  cnt_wdata;
	logic [COUNT_W-1:0]  count_rdata;
	logic                name_re;
	logic [AW-1:0]       name_raddr;
	logic [NAME_W-1:0]   name_rdata;

	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_LIST_LIMIT) ? DATA_W'(list_limit_q) : '0;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign issue_en   = ((state_q == S_REC_SCAN) || (state_q == S_EMIT_SCAN)) &&
	                    (issue_q < entry_count_q);
	assign scan_last  = v_s1 && ((CW'(idx_s1) + CW'(1)) == entry_count_q);
	assign name_match = (name_rdata == key_q);
	assign count_inc  = (count_rdata == COUNT_MAX) ? count_rdata : count_rdata + COUNT_W'(1);

	assign eligible = first_q || (count_rdata < prev_count_q) ||
	                  ((count_rdata == prev_count_q) && (idx_s1 > prev_idx_q));
	assign take     = (state_q == S_EMIT_SCAN) && v_s1 && eligible &&
	                  (!best_valid_q || (count_rdata > best_count_q));
	assign best_idx_nxt   = take ? idx_s1 : best_idx_q;
	assign best_count_nxt = take ? count_rdata : best_count_q;
	assign emit_end       = (state_q == S_EMIT_SCAN) && scan_last;
	assign out_free       = !result_valid_q || result_ready;
	assign out_load       = ((state_q == S_EMIT_OUT) || (state_q == S_EMIT_EMPTY)) && out_free;
	assign last_w         = ((rank_q + RW'(1)) == k_q);

	assign rec_hit   = (state_q == S_REC_SCAN) && v_s1 && name_match;
	assign append    = (state_q == S_REC_APPEND) && (entry_count_q < FULL);
	assign cnt_we    = rec_hit || append;
	assign cnt_waddr = rec_hit ? idx_s1 : entry_count_q[AW-1:0];
	assign cnt_wdata = rec_hit ? count_inc : COUNT_W'(1);

	assign name_re    = (issue_en && (state_q == S_REC_SCAN)) || emit_end;
	assign name_raddr = emit_end ? best_idx_nxt : issue_q[AW-1:0];

	always_comb begin
		int lim_i;
		lim_i = int'(list_limit_q);
		if (lim_i < 1) begin
			lim_i = 1;
		end
		if (lim_i > LIST_MAX) begin
			lim_i = LIST_MAX;
		end
		if (int'(entry_count_q) < lim_i) begin
			lim_i = int'(entry_count_q);
		end
		k_nxt = RW'(lim_i);
	end

	dhtr_ram #(
		.WIDTH (NAME_W),
		.DEPTH (TABLE_ENTRIES)
	) u_name_ram (
		.clk   (clk),
		.we    (append),
		.waddr (entry_count_q[AW-1:0]),
		.wdata (key_q),
		.re    (name_re),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	dhtr_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (issue_en),
		.raddr (issue_q[AW-1:0]),
		.rdata (count_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			list_limit_q   <= LIST_LIMIT_RST;
			entry_count_q  <= '0;
			key_q          <= '0;
			issue_q        <= '0;
			v_s1           <= 1'b0;
			idx_s1         <= '0;
			best_valid_q   <= 1'b0;
			best_count_q   <= '0;
			best_idx_q     <= '0;
			prev_count_q   <= '0;
			prev_idx_q     <= '0;
			first_q        <= 1'b0;
			rank_q         <= '0;
			k_q            <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_wr && (reg_idx == REG_LIST_LIMIT)) begin
				list_limit_q <= pwdata[LIMIT_W-1:0];
			end
			v_s1   <= issue_en;
			idx_s1 <= issue_q[AW-1:0];
			if (issue_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						case (item.opcode)
							OP_CLEAR: begin
								entry_count_q <= '0;
							end
							OP_RECORD: begin
								key_q   <= item.doc_name;
								issue_q <= '0;
								state_q <= (entry_count_q == '0) ? S_REC_APPEND : S_REC_SCAN;
							end
							OP_EMIT: begin
								if (entry_count_q == '0) begin
									state_q <= S_EMIT_EMPTY;
								end else begin
									k_q          <= k_nxt;
									rank_q       <= '0;
									first_q      <= 1'b1;
									issue_q      <= '0;
									best_valid_q <= 1'b0;
									state_q      <= S_EMIT_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_REC_SCAN: begin
					if (rec_hit) begin
						state_q <= S_IDLE;
					end else if (scan_last) begin
						state_q <= S_REC_APPEND;
					end
				end
				S_REC_APPEND: begin
					if (append) begin
						entry_count_q <= entry_count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				S_EMIT_SCAN: begin
					if (take) begin
						best_valid_q <= 1'b1;
					end
					best_idx_q   <= best_idx_nxt;
					best_count_q <= best_count_nxt;
					if (scan_last) begin
						state_q <= S_EMIT_OUT;
					end
				end
				S_EMIT_OUT: begin
					if (out_free) begin
						result_q.ranked_name <= name_rdata;
						result_q.hit_count   <= best_count_q;
						result_q.rank        <= RANK_W'(rank_q);
						result_q.empty_list  <= 1'b0;
						result_q.last        <= last_w;
						prev_count_q         <= best_count_q;
						prev_idx_q           <= best_idx_q;
						first_q              <= 1'b0;
						best_valid_q         <= 1'b0;
						issue_q              <= '0;
						rank_q               <= rank_q + RW'(1);
						state_q              <= last_w ? S_IDLE : S_EMIT_SCAN;
					end
				end
				S_EMIT_EMPTY: begin
					if (out_free) begin
						result_q.ranked_name <= '0;
						result_q.hit_count   <= '0;
						result_q.rank        <= '0;
						result_q.empty_list  <= 1'b1;
						result_q.last        <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
